>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files that carry concurrent checks.
// Depends on nothing; the including module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(label, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error(msg);

`endif

>>> rtl/b64d_pkg.sv
// Shared types, constants and the alphabet lookup of the base64url decoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package b64d_pkg;

    localparam int DEF_COUNT_WIDTH = 16;
    localparam int CAP_W           = 16;
    localparam int TOTAL_W         = 16;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] ST_DATA     = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_BADLEN   = 3'd2;
    localparam logic [2:0] ST_BADCHAR  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'hffff;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_DASH    = 8'h2d;
    localparam logic [7:0] CHAR_USCORE  = 8'h5f;

    // One queue entry: the bytes a character releases plus its optional status.
    typedef struct packed {
        logic [23:0]        group_bits;
        logic [1:0]         nbytes;
        logic [TOTAL_W-1:0] base_total;
        logic               has_status;
        logic [2:0]         status;
        logic [TOTAL_W-1:0] final_total;
    } rec_t;

    // Returns {valid, sextet} for one character of the URL-safe alphabet.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [7:0] d;
        logic [6:0] r;
        d = 8'h00;
        r = 7'h00;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            d = c - CHAR_UPPER_A;
            r = {1'b1, d[5:0]};
        end
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
        begin
            d = c - CHAR_LOWER_A + 8'd26;
            r = {1'b1, d[5:0]};
        end
        else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
        begin
            d = c - CHAR_DIGIT_0 + 8'd52;
            r = {1'b1, d[5:0]};
        end
        else if (c == CHAR_DASH)
        begin
            r = {1'b1, 6'd62};
        end
        else if (c == CHAR_USCORE)
        begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

endpackage

>>> rtl/b64d_front.sv
// Front part of the decoder: accepts characters, packs sextets and checks groups.
// Depends on b64d_pkg; writes one rec_t into the queue for each character with results.
module b64d_front #(
    parameter int COUNT_WIDTH = b64d_pkg::DEF_COUNT_WIDTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [7:0]               char_code,
    input  logic                     message_last,
    input  logic                     cap_we,
    input  logic [b64d_pkg::CAP_W-1:0] cap_data,
    input  logic                     q_full,
    output logic                     q_push,
    output b64d_pkg::rec_t           q_rec
);
    import b64d_pkg::*;

    localparam int EXT_W = (COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W;
    localparam int CMP_W = EXT_W + 1;

    logic [CAP_W-1:0]       cap_reg;
    logic [17:0]            buf_reg, buf_next;
    logic [1:0]             pos_reg, pos_next;
    logic                   bad_reg, bad_next;
    logic [2:0]             err_reg, err_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    logic                   accept;
    logic [6:0]             lookup;
    logic                   bad_now;
    logic                   check;
    logic [1:0]             nb;
    logic [23:0]            grp;
    logic [CMP_W-1:0]       sum;
    logic                   ovf;
    logic                   emit;
    logic [EXT_W-1:0]       base_ext, final_ext;

    assign full    = q_full;
    assign accept  = push && !q_full;
    assign lookup  = sextet_of(char_code);
    assign bad_now = bad_reg || !lookup[6];

    // A group closes on its fourth character, or on a tail of two or three.
    assign check = (pos_reg == 2'd3) || (message_last && (pos_reg != 2'd0));

    always_comb
    begin
        unique case (pos_reg)
            2'd1:
            begin
                nb  = 2'd1;
                grp = {buf_reg[5:0], lookup[5:0], 12'h000};
            end
            2'd2:
            begin
                nb  = 2'd2;
                grp = {buf_reg[11:0], lookup[5:0], 6'h00};
            end
            2'd3:
            begin
                nb  = 2'd3;
                grp = {buf_reg, lookup[5:0]};
            end
            default:
            begin
                nb  = 2'd0;
                grp = 24'h000000;
            end
        endcase
    end

    assign sum  = CMP_W'(count_reg) + CMP_W'(nb);
    assign ovf  = (sum > CMP_W'(cap_reg)) || sum[COUNT_WIDTH];
    assign emit = check && (err_reg == ST_DATA) && !bad_now && !ovf;

    always_comb
    begin
        err_next = err_reg;
        if (check && err_reg == ST_DATA)
        begin
            if (bad_now)
                err_next = ST_BADCHAR;
            else if (ovf)
                err_next = ST_OVERFLOW;
        end
    end

    assign count_next = emit ? sum[COUNT_WIDTH-1:0] : count_reg;
    assign base_ext   = EXT_W'(count_reg);
    assign final_ext  = EXT_W'(count_next);

    always_comb
    begin
        q_rec.group_bits  = grp;
        q_rec.nbytes      = emit ? nb : 2'd0;
        q_rec.base_total  = base_ext[TOTAL_W-1:0];
        q_rec.has_status  = message_last;
        q_rec.final_total = final_ext[TOTAL_W-1:0];
        if (pos_reg == 2'd0)
            q_rec.status = ST_BADLEN;
        else if (err_next != ST_DATA)
            q_rec.status = err_next;
        else
            q_rec.status = ST_OK;
    end

    assign q_push = accept && (emit || message_last);

    always_comb
    begin
        buf_next = buf_reg;
        pos_next = pos_reg;
        bad_next = bad_reg;
        if (message_last)
        begin
            buf_next = 18'h00000;
            pos_next = 2'd0;
            bad_next = 1'b0;
        end
        else if (pos_reg == 2'd3)
        begin
            buf_next = 18'h00000;
            pos_next = 2'd0;
            bad_next = 1'b0;
        end
        else
        begin
            buf_next = {buf_reg[11:0], lookup[5:0]};
            pos_next = pos_reg + 2'd1;
            bad_next = bad_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            buf_reg   <= '0;
            pos_reg   <= '0;
            bad_reg   <= 1'b0;
            err_reg   <= ST_DATA;
            count_reg <= '0;
        end
        else
        begin
            if (cap_we)
                cap_reg <= cap_data;
            if (accept)
            begin
                buf_reg <= buf_next;
                pos_reg <= pos_next;
                bad_reg <= bad_next;
                if (message_last)
                begin
                    err_reg   <= ST_DATA;
                    count_reg <= '0;
                end
                else
                begin
                    err_reg   <= err_next;
                    count_reg <= count_next;
                end
            end
        end
    end

endmodule

>>> rtl/b64d_queue.sv
// Short queue of decoded records between the front and back parts.
// Depends on b64d_pkg for rec_t and the queue depth.
module b64d_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b64d_pkg::rec_t push_rec,
    output logic           q_full,
    input  logic           pop,
    output b64d_pkg::rec_t pop_rec,
    output logic           q_empty
);
    import b64d_pkg::*;

    rec_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign q_full  = (cnt_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_push = push && !q_full;
    assign do_pop  = pop && !q_empty;
    assign pop_rec = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> rtl/b64d_back.sv
// Back part of the decoder: unpacks a record into results, one per popped cycle.
// Depends on b64d_pkg for rec_t and the status codes.
module b64d_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  b64d_pkg::rec_t               q_rec,
    output logic                         q_pop,
    output logic                         empty,
    input  logic                         pop,
    output logic [7:0]                   out_byte,
    output logic [2:0]                   status,
    output logic [b64d_pkg::TOTAL_W-1:0] total_bytes,
    output logic                         run_last
);
    import b64d_pkg::*;

    rec_t       cur_reg;
    logic       cur_valid_reg;
    logic [1:0] idx_reg;
    logic [1:0] last_idx;
    logic       is_data;
    logic       done_now;
    logic       load;

    // Data items come first, then the status item if the record has one.
    assign last_idx = cur_reg.has_status ? cur_reg.nbytes : (cur_reg.nbytes - 2'd1);
    assign is_data  = (idx_reg < cur_reg.nbytes);
    assign done_now = pop && cur_valid_reg && (idx_reg == last_idx);
    assign load     = (!cur_valid_reg || done_now) && !q_empty;
    assign q_pop    = load;

    assign empty    = !cur_valid_reg;
    assign run_last = (idx_reg == last_idx);
    assign status   = is_data ? ST_DATA : cur_reg.status;

    always_comb
    begin
        out_byte = 8'h00;
        if (is_data)
        begin
            unique case (idx_reg)
                2'd0:    out_byte = cur_reg.group_bits[23:16];
                2'd1:    out_byte = cur_reg.group_bits[15:8];
                default: out_byte = cur_reg.group_bits[7:0];
            endcase
        end
    end

    assign total_bytes = is_data
        ? (cur_reg.base_total + TOTAL_W'(idx_reg) + TOTAL_W'(1))
        : cur_reg.final_total;

    always_ff @(posedge clk)
    begin
        if (load)
            cur_reg <= q_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else if (load)
        begin
            cur_valid_reg <= 1'b1;
            idx_reg       <= 2'd0;
        end
        else if (done_now)
        begin
            cur_valid_reg <= 1'b0;
        end
        else if (pop && cur_valid_reg)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

>>> rtl/base64url_stream_decoder_unit.sv
// Top level of the unpadded base64url stream decoder.
// Depends on b64d_pkg, assert_macros.svh, b64d_front, b64d_queue and b64d_back.
//
// Usage: characters enter through a queue-style port (push/full) with
// message_last set on the final character of each message. Results leave
// through a second queue-style port (empty/pop): each result carries
// out_byte, status, total_bytes and run_last, where run_last marks the last
// result caused by a character. A fourth character of a group releases three
// data bytes; the final character also releases a tail of one or two bytes
// and one status result. Other characters release nothing.
// The front takes one character per cycle while full is low: lookup, packing
// and the group check all finish in that cycle, and the record goes into a
// four-entry queue. A result passes through the queue slot and the back's
// record register before it shows on the output. The back hands out one
// result per cycle while pop is high; full rises only once the queue has
// filled behind a stalled or slow receiver.
// output_capacity is written through cfg_valid/cfg_data, always ready, and
// should only change while the block is idle. Reset clears the group state,
// the byte count, the queue and the output stage, and sets the capacity to
// 65535; no clearing pass is needed and the block accepts items right away.
module base64url_stream_decoder_unit #(
    parameter int COUNT_WIDTH = b64d_pkg::DEF_COUNT_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [7:0]                   char_code,
    input  logic                         message_last,
    output logic                         empty,
    input  logic                         pop,
    output logic [7:0]                   out_byte,
    output logic [2:0]                   status,
    output logic [b64d_pkg::TOTAL_W-1:0] total_bytes,
    output logic                         run_last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [b64d_pkg::CAP_W-1:0]   cfg_data
);
    import b64d_pkg::*;

    `include "assert_macros.svh"

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    rec_t push_rec;
    rec_t pop_rec;

    // The capacity register can take a write in any cycle.
    assign cfg_ready = 1'b1;

    b64d_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .char_code    (char_code),
        .message_last (message_last),
        .cap_we       (cfg_valid && cfg_ready),
        .cap_data     (cfg_data),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_rec        (push_rec)
    );

    b64d_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (push_rec),
        .q_full   (q_full),
        .pop      (q_pop),
        .pop_rec  (pop_rec),
        .q_empty  (q_empty)
    );

    b64d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_rec       (pop_rec),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .status      (status),
        .total_bytes (total_bytes),
        .run_last    (run_last)
    );

    // A status result always closes the run of results for its character.
    `ASSERT_CLK(a_status_is_last, !empty && status != ST_DATA |-> run_last, "status result without run_last")

    // The front never writes a record into a full queue.
    `ASSERT_CLK(a_no_queue_overrun, q_push |-> !q_full, "queue written while full")

    // An idle output stage picks up a waiting record at the next edge.
    `ASSERT_NEXT(a_back_loads, empty && !q_empty, !empty, "waiting record not loaded")

    // A status result never carries a nonzero byte.
    `ASSERT_CLK(a_status_byte_zero, !empty && status != ST_DATA |-> out_byte == 8'h00, "status result with nonzero byte")

endmodule

>>> sim/tb_base64url_stream_decoder_unit.sv
// Self-checking testbench for the unpadded base64url stream decoder.
// Depends on b64d_pkg and base64url_stream_decoder_unit; a model inside predicts every result.

module tb_base64url_stream_decoder_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import b64d_pkg::*;

    // The message error register holds zero while no error has been seen.
    localparam logic [2:0] NO_ERROR = 3'd0;

    // Reset length, receiver hold-off, idle cycles after the last result, print cap.
    localparam int RESET_CYCLES = 12;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_SLACK  = 6;
    localparam int MAX_REPORTS  = 50;

    // Hard stop, far beyond the slowest legal run.
    localparam int TIMEOUT_NS = 2_000_000;

    // Receiver behavior: always ready, random stalls, or a fixed repeating stall.
    typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_PATTERN} rx_style_t;

    // One decoded result as the block should present it.
    typedef struct packed {
        logic [7:0]         data;
        logic [2:0]         code;
        logic [TOTAL_W-1:0] count;
        logic               final_of_char;
    } decoded_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               push         = 1'b0;
    logic               full;
    logic [7:0]         char_code    = 8'h00;
    logic               message_last = 1'b0;
    logic               empty;
    logic               pop          = 1'b0;
    logic [7:0]         out_byte;
    logic [2:0]         status;
    logic [TOTAL_W-1:0] total_bytes;
    logic               run_last;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [CAP_W-1:0]   cfg_data     = '0;

    base64url_stream_decoder_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .char_code    (char_code),
        .message_last (message_last),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .status       (status),
        .total_bytes  (total_bytes),
        .run_last     (run_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // URL-safe alphabet. It builds the decode table and also lets the stimulus
    // turn a random sextet into a legal character.
    string url_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
    bit         sextet_valid [256];
    logic [5:0] sextet_value [256];

    // Decoder model state. The capacity survives the end of a message; the
    // rest is cleared after every final character.
    logic [CAP_W-1:0]   cap_model     = CAP_RESET;
    logic [17:0]        group_sextets = '0;
    logic [1:0]         group_fill    = '0;
    bit                 group_bad     = 1'b0;
    logic [2:0]         msg_error     = NO_ERROR;
    logic [TOTAL_W-1:0] msg_bytes     = '0;

    // Results caused by the character being modeled, then all that are still owed.
    decoded_t group_results [$];
    decoded_t pending_results [$];

    int unsigned chars_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;

    // Sender pacing: bursts of items with idle gaps in between when enabled.
    bit          tx_bursty  = 1'b0;
    int unsigned burst_left = 0;

    // Receiver pacing. The test bumps hold_token to ask for one long hold-off;
    // the receiver counts it down on its own.
    rx_style_t   rx_style   = RX_STEADY;
    int unsigned hold_token = 0;
    int unsigned hold_seen  = 0;
    int unsigned hold_left  = 0;
    int unsigned rx_phase   = 0;

    // Prints one line per mismatch, up to a cap, and counts all of them.
    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic check_field(input string field, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            log_mismatch($sformatf("result %0d %s: got %0h, wanted %0h",
                                   results_seen, field, got, want));
    endtask

    // Closes one group (a full group or the final tail). A bad character is
    // checked before the capacity, and only the first error of a message sticks.
    task automatic close_group(input logic [23:0] bits, input int unsigned nbytes);
        decoded_t    item;
        int unsigned reach;
        if (msg_error != NO_ERROR)
            return;
        if (group_bad)
        begin
            msg_error = ST_BADCHAR;
            return;
        end
        // The capacity is never above the largest count, so this covers both limits.
        reach = msg_bytes + nbytes;
        if (reach > cap_model)
        begin
            msg_error = ST_OVERFLOW;
            return;
        end
        for (int i = 0; i < nbytes; i++)
        begin
            msg_bytes++;
            item.data          = bits[23 - 8 * i -: 8];
            item.code          = ST_DATA;
            item.count         = msg_bytes;
            item.final_of_char = 1'b0;
            group_results.push_back(item);
        end
    endtask

    // Advances the model by one accepted character and queues what it causes.
    task automatic decode_char(input logic [7:0] c, input bit is_last);
        logic [5:0]  v;
        logic [1:0]  pos;
        logic [17:0] grown;
        logic [2:0]  outcome;
        decoded_t    item;
        group_results.delete();
        v = sextet_value[c];
        if (!sextet_valid[c])
            group_bad = 1'b1;
        pos   = group_fill;
        grown = {group_sextets[11:0], v};
        if (pos == 2'd3)
        begin
            close_group({group_sextets, v}, 3);
            group_sextets = '0;
            group_fill    = '0;
            group_bad     = 1'b0;
        end
        else
        begin
            group_sextets = grown;
            group_fill    = pos + 2'd1;
        end
        if (is_last)
        begin
            // A lone trailing character is a bad length, whatever came before.
            if (pos == 2'd0)
                outcome = ST_BADLEN;
            else
            begin
                if (pos == 2'd1)
                    close_group({grown[11:0], 12'h000}, 1);
                else if (pos == 2'd2)
                    close_group({grown, 6'h00}, 2);
                outcome = (msg_error != NO_ERROR) ? msg_error : ST_OK;
            end
            item.data          = 8'h00;
            item.code          = outcome;
            item.count         = msg_bytes;
            item.final_of_char = 1'b0;
            group_results.push_back(item);
            group_sextets = '0;
            group_fill    = '0;
            group_bad     = 1'b0;
            msg_error     = NO_ERROR;
            msg_bytes     = '0;
        end
        if (group_results.size() != 0)
        begin
            item = group_results.pop_back();
            item.final_of_char = 1'b1;
            group_results.push_back(item);
        end
        foreach (group_results[i])
            pending_results.push_back(group_results[i]);
    endtask

    // Offers one character and returns at the edge where it is taken. When the
    // sender runs in bursts, an idle gap of random length opens each burst.
    task automatic send_char(input logic [7:0] c, input bit is_last);
        int unsigned gap;
        if (tx_bursty)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(0, 6);
                if (gap != 0)
                begin
                    push <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
        end
        push         <= 1'b1;
        char_code    <= c;
        message_last <= is_last;
        do
            @(posedge clk);
        while (!(push && !full));
        decode_char(c, is_last);
        chars_sent++;
    endtask

    task automatic send_text(input string s, input bit ends_message);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], ends_message && (i == s.len() - 1));
    endtask

    // One message of random content. bad_pct is the chance that a character is
    // drawn from the whole byte range instead of the alphabet.
    task automatic send_random_message(input int unsigned nchars, input int unsigned bad_pct);
        logic [7:0] c;
        for (int i = 0; i < nchars; i++)
        begin
            if ($urandom_range(0, 99) < bad_pct)
                c = 8'($urandom_range(0, 255));
            else
                c = url_alphabet[$urandom_range(0, 63)];
            send_char(c, i == nchars - 1);
        end
    endtask

    // Stops offering items and waits until every owed result has been taken, then
    // idles for the DRAIN_SLACK margin in case the last item is still inside the block.
    task automatic wait_until_drained();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    // Writes output_capacity; only called while the block is idle.
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cap_model = value;
        cfg_valid <= 1'b0;
    endtask

    // Result side: check what is taken at this edge, then decide whether to
    // take the next one. A hold-off request overrides the stall style.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
                log_mismatch($sformatf("unexpected result %0d: byte %0h status %0d total %0d",
                                       results_seen, out_byte, status, total_bytes));
            else
            begin
                decoded_t want;
                want = pending_results.pop_front();
                check_field("out_byte", 16'(out_byte), 16'(want.data));
                check_field("status", 16'(status), 16'(want.code));
                check_field("total_bytes", total_bytes, want.count);
                check_field("run_last", 16'(run_last), 16'(want.final_of_char));
            end
            results_seen++;
        end
        rx_phase++;
        if (hold_seen != hold_token)
        begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
        begin
            case (rx_style)
                RX_RANDOM:  pop <= ($urandom_range(0, 99) < 55);
                RX_PATTERN: pop <= ((rx_phase % 7) >= 3);
                default:    pop <= 1'b1;
            endcase
        end
    end

    // Letters A, Z, a and z, digits 0 and 9 and both URL-safe symbols, then tails
    // of two and three characters. The two-character tail leaves nonzero spare bits.
    task automatic test_alphabet_and_tails();
        wait_until_drained();
        write_capacity(CAP_RESET);
        rx_style <= RX_RANDOM;
        tx_bursty = 1'b1;
        send_text("AZaz09-_", 1'b1);
        send_text("QR", 1'b1);
        send_text("QUJ", 1'b1);
    endtask

    // The lowest and highest byte as invalid characters in one group, then a
    // bad group followed by a lone tail character, where bad length wins.
    task automatic test_bad_characters();
        send_char(8'h00, 1'b0);
        send_text("AB", 1'b0);
        send_char(8'hff, 1'b1);
        send_text("@AAAB", 1'b1);
    endtask

    // Zero capacity with a bad character shows the character check comes
    // first; then a plain overflow; then a capacity change between groups of
    // one message, which applies from the next group on.
    task automatic test_capacity_limits();
        wait_until_drained();
        write_capacity('0);
        rx_style <= RX_PATTERN;
        send_text("QU:", 1'b1);
        send_text("QR", 1'b1);
        wait_until_drained();
        write_capacity(16'd3);
        send_text("QUJD", 1'b0);
        wait_until_drained();
        write_capacity(16'd2);
        send_text("QQ", 1'b1);
    endtask

    // The receiver holds off for a long stretch while a long message streams
    // in without gaps, so the block has to fill up and push back on input.
    task automatic test_backpressure();
        wait_until_drained();
        write_capacity(CAP_RESET);
        rx_style   <= RX_STEADY;
        tx_bursty  = 1'b0;
        hold_token <= hold_token + 1;
        send_random_message(32, 0);
        wait_until_drained();
    endtask

    // Random messages: mostly short and well formed, some long, and about one
    // in ten made of arbitrary bytes.
    task automatic run_random_messages(input logic [CAP_W-1:0] cap, input int unsigned nchars,
                                       input rx_style_t style, input bit bursty);
        int unsigned stop_at;
        int unsigned len;
        int unsigned bad_pct;
        wait_until_drained();
        write_capacity(cap);
        rx_style <= style;
        tx_bursty = bursty;
        stop_at = chars_sent + nchars;
        while (chars_sent < stop_at)
        begin
            len     = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20)
                                                  : $urandom_range(1, 9);
            bad_pct = ($urandom_range(0, 9) == 0) ? 100 : 4;
            send_random_message(len, bad_pct);
        end
    endtask

    task automatic test_random_full_capacity();
        run_random_messages(CAP_RESET, 30, RX_RANDOM, 1'b1);
    endtask

    // Capacities near typical message sizes, where overflow is common.
    task automatic test_random_small_capacity();
        for (int k = 0; k < 4; k++)
            run_random_messages(CAP_W'($urandom_range(0, 12)), 8,
                                (k % 2) ? RX_PATTERN : RX_RANDOM, k != 0);
    endtask

    task automatic test_random_zero_capacity();
        run_random_messages('0, 12, RX_STEADY, 1'b1);
    endtask

    task automatic test_random_mid_capacity();
        run_random_messages(CAP_W'($urandom_range(13, 65534)), 25, RX_PATTERN, 1'b0);
    endtask

    initial
    begin
        for (int i = 0; i < 256; i++)
        begin
            sextet_valid[i] = 1'b0;
            sextet_value[i] = '0;
        end
        for (int v = 0; v < 64; v++)
        begin
            sextet_valid[url_alphabet[v]] = 1'b1;
            sextet_value[url_alphabet[v]] = 6'(v);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_alphabet_and_tails();
        test_bad_characters();
        test_capacity_limits();
        test_backpressure();
        test_random_full_capacity();
        test_random_small_capacity();
        test_random_zero_capacity();
        test_random_mid_capacity();

        // Let the receiver take everything, then watch a while for strays.
        rx_style <= RX_STEADY;
        wait_until_drained();
        repeat (DRAIN_SLACK) @(posedge clk);
        if (mismatches == 0)
            $display("base64url_stream_decoder_unit regression: pass");
        else
            $display("base64url_stream_decoder_unit regression: fail");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("TIMEOUT with %0d results still owed", pending_results.size());
        $display("base64url_stream_decoder_unit regression: fail");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/b64d_pkg.sv
rtl/b64d_front.sv
rtl/b64d_queue.sv
rtl/b64d_back.sv
rtl/base64url_stream_decoder_unit.sv
sim/tb_base64url_stream_decoder_unit.sv
